// File: sv/vshp_pkg.sv
package vshp_pkg;

    // Field parser steps. The value of a step that emits its own field is
    // also the field code that goes out with it.
    typedef enum logic [4:0] {
        STEP_PROFILE   = 5'd0,
        STEP_LEVEL     = 5'd1,
        STEP_CHROMA    = 5'd2,
        STEP_FRMRTQ    = 5'd3,
        STEP_BITRTQ    = 5'd4,
        STEP_POSTPROC  = 5'd5,
        STEP_WIDTH     = 5'd6,
        STEP_HEIGHT    = 5'd7,
        STEP_BROADCAST = 5'd8,
        STEP_INTERLACE = 5'd9,
        STEP_TFCNTR    = 5'd10,
        STEP_FINTERP   = 5'd11,
        STEP_RESERVED  = 5'd12,
        STEP_PSF       = 5'd13,
        STEP_DISP_INFO = 5'd14,
        STEP_DISP_W    = 5'd15,
        STEP_DISP_H    = 5'd16,
        STEP_AR_FLAG   = 5'd17,
        STEP_AR_CODE   = 5'd18,
        STEP_PIX_W     = 5'd19,
        STEP_PIX_H     = 5'd20,
        STEP_FR_FLAG   = 5'd21,
        STEP_RATE_SEL  = 5'd22,
        STEP_RATE_VAL  = 5'd23,
        STEP_RATE_NR   = 5'd24,
        STEP_RATE_DR   = 5'd25,
        STEP_DONE      = 5'd26
    } step_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SHORT   = 2'd1,
        STATUS_NOT_ADV = 2'd2
    } status_t;

    localparam logic [4:0] CODE_TIMESCALE = 5'd22;
    localparam logic [4:0] CODE_DURATION  = 5'd23;
    localparam logic [3:0] AR_CODE_PIXEL  = 4'd15;
    localparam logic [16:0] FIXED_DURATION = 17'd32;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  field_code;
        logic [16:0] field_value;
        logic        is_summary;
        logic [1:0]  status;
        logic [15:0] bytes_left;
        logic        last;
    } out_item_t;

    // Byte after classification by the front end.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        end_of_buffer;
        logic        in_header;
        logic [15:0] byte_count;
    } queue_item_t;

    function automatic logic [4:0] step_width(step_t step);
        logic [4:0] w;
        unique case (step)
            STEP_PROFILE, STEP_CHROMA:               w = 5'd2;
            STEP_LEVEL, STEP_FRMRTQ:                 w = 5'd3;
            STEP_BITRTQ:                             w = 5'd5;
            STEP_WIDTH, STEP_HEIGHT:                 w = 5'd12;
            STEP_DISP_W, STEP_DISP_H:                w = 5'd14;
            STEP_AR_CODE, STEP_RATE_DR:              w = 5'd4;
            STEP_PIX_W, STEP_PIX_H, STEP_RATE_NR:    w = 5'd8;
            STEP_RATE_VAL:                           w = 5'd16;
            default:                                 w = 5'd1;
        endcase
        return w;
    endfunction

    // Frame rate numerator for table index 1..5.
    function automatic logic [16:0] rate_numerator(logic [2:0] idx);
        logic [16:0] v;
        case (idx)
            3'd1:    v = 17'd24000;
            3'd2:    v = 17'd25000;
            3'd3:    v = 17'd30000;
            3'd4:    v = 17'd50000;
            default: v = 17'd60000;
        endcase
        return v;
    endfunction

    // Frame rate denominator for table index 1..2.
    function automatic logic [16:0] rate_denominator(logic second);
        return second ? 17'd1001 : 17'd1000;
    endfunction

endpackage

// File: sv/vshp_stream_if.sv
interface vshp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/vshp_front.sv
module vshp_front #(
    parameter int MAX_BUFFER_BYTES = 65535,
    parameter int START_CODE_BYTES = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    vshp_stream_if.sink   byte_in,
    vshp_stream_if.source queue_out
);
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [15:0] count_inc;
    logic        accept;

    // Counts bytes of the current buffer, saturating, and marks start code bytes.
    assign count_inc = (count_reg < 16'(MAX_BUFFER_BYTES)) ? count_reg + 16'd1 : count_reg;
    assign accept    = byte_in.valid && byte_in.ready;

    assign byte_in.ready   = queue_out.ready;
    assign queue_out.valid = byte_in.valid;
    assign queue_out.payload.data_byte     = byte_in.payload.data_byte;
    assign queue_out.payload.end_of_buffer = byte_in.payload.end_of_buffer;
    assign queue_out.payload.in_header     = (count_reg >= 16'(START_CODE_BYTES));
    assign queue_out.payload.byte_count    = count_inc;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = byte_in.payload.end_of_buffer ? 16'd0 : count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 16'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end
endmodule

// File: sv/vshp_queue.sv
module vshp_queue (
    input  logic          clk,
    input  logic          rst_n,
    vshp_stream_if.sink   push,
    vshp_stream_if.source pop
);
    localparam int PTR_W = $clog2(vshp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(vshp_pkg::QUEUE_DEPTH + 1);

    vshp_pkg::queue_item_t entry_reg [vshp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign push.ready  = (fill_reg != CNT_W'(vshp_pkg::QUEUE_DEPTH));
    assign pop.valid   = (fill_reg != '0);
    assign pop.payload = entry_reg[rd_ptr_reg];
    assign do_push     = push.valid && push.ready;
    assign do_pop      = pop.valid && pop.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(vshp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(vshp_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.payload;
        end
    end
endmodule

// File: sv/vshp_back.sv
module vshp_back #(
    parameter int START_CODE_BYTES = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    vshp_stream_if.sink   queue_in,
    vshp_stream_if.source field_out
);
    vshp_pkg::step_t     step_reg, step_next;
    logic [15:0]         acc_reg, acc_next;
    logic [4:0]          fbits_reg, fbits_next;
    logic [7:0]          cbits_reg, cbits_next;
    logic [7:0]          nr_idx_reg, nr_idx_next;
    logic [1:0]          pstat_reg, pstat_next;
    logic [3:0]          bpos_reg, bpos_next;
    logic                pend_reg, pend_next;
    logic [16:0]         pend_val_reg, pend_val_next;
    logic                ov_reg, ov_next;
    vshp_pkg::out_item_t od_reg, od_next;

    vshp_pkg::queue_item_t head;
    vshp_pkg::out_item_t   item;
    logic        emit;
    logic        out_free;
    logic        active;
    logic [4:0]  need;
    logic [3:0]  avail;
    logic [3:0]  take;
    logic [7:0]  rem;
    logic [7:0]  chunk;
    logic [15:0] acc_new;
    logic [3:0]  bpos_new;
    logic        finished;
    logic [15:0] used;
    logic [1:0]  sum_status;

    assign head     = queue_in.payload;
    assign out_free = !ov_reg || field_out.ready;
    assign active   = head.in_header && (step_reg != vshp_pkg::STEP_DONE)
                      && (bpos_reg != 4'd8);

    // Bits of the current byte are taken in chunks that never cross a field end.
    assign need     = vshp_pkg::step_width(step_reg) - fbits_reg;
    assign avail    = 4'd8 - bpos_reg;
    assign take     = (need < {1'b0, avail}) ? need[3:0] : avail;
    assign rem      = head.data_byte << bpos_reg;
    assign chunk    = rem >> (4'd8 - take);
    assign acc_new  = (acc_reg << take) | {8'd0, chunk};
    assign bpos_new = bpos_reg + take;

    assign used       = 16'(START_CODE_BYTES) + {11'd0, cbits_reg[7:3]};
    assign sum_status = (step_reg != vshp_pkg::STEP_DONE) ? vshp_pkg::STATUS_SHORT : pstat_reg;

    assign field_out.valid   = ov_reg;
    assign field_out.payload = od_reg;

    always_comb
    begin
        step_next     = step_reg;
        acc_next      = acc_reg;
        fbits_next    = fbits_reg;
        cbits_next    = cbits_reg;
        nr_idx_next   = nr_idx_reg;
        pstat_next    = pstat_reg;
        bpos_next     = bpos_reg;
        pend_next     = pend_reg;
        pend_val_next = pend_val_reg;
        queue_in.ready = 1'b0;
        emit          = 1'b0;
        item          = '0;
        finished      = 1'b0;

        if (out_free)
        begin
            if (pend_reg)
            begin
                emit              = 1'b1;
                item.field_code   = vshp_pkg::CODE_DURATION;
                item.field_value  = pend_val_reg;
                pend_next         = 1'b0;
            end
            else if (queue_in.valid && active)
            begin
                cbits_next = cbits_reg + {4'd0, take};
                if ({1'b0, take} == need)
                begin
                    acc_next         = 16'd0;
                    fbits_next       = 5'd0;
                    item.field_code  = 5'(step_reg);
                    item.field_value = {1'b0, acc_new};
                    unique case (step_reg)
                        vshp_pkg::STEP_PROFILE:
                        begin
                            emit = 1'b1;
                            if (acc_new == 16'd3)
                            begin
                                step_next = vshp_pkg::STEP_LEVEL;
                            end
                            else
                            begin
                                step_next  = vshp_pkg::STEP_DONE;
                                pstat_next = vshp_pkg::STATUS_NOT_ADV;
                            end
                        end
                        vshp_pkg::STEP_DISP_INFO:
                        begin
                            emit      = 1'b1;
                            step_next = acc_new[0] ? vshp_pkg::STEP_DISP_W
                                                   : vshp_pkg::STEP_DONE;
                        end
                        vshp_pkg::STEP_AR_FLAG:
                        begin
                            emit      = 1'b1;
                            step_next = acc_new[0] ? vshp_pkg::STEP_AR_CODE
                                                   : vshp_pkg::STEP_FR_FLAG;
                        end
                        vshp_pkg::STEP_AR_CODE:
                        begin
                            emit      = 1'b1;
                            step_next = (acc_new[3:0] == vshp_pkg::AR_CODE_PIXEL)
                                        ? vshp_pkg::STEP_PIX_W : vshp_pkg::STEP_FR_FLAG;
                        end
                        vshp_pkg::STEP_FR_FLAG:
                        begin
                            emit      = 1'b1;
                            step_next = acc_new[0] ? vshp_pkg::STEP_RATE_SEL
                                                   : vshp_pkg::STEP_DONE;
                        end
                        vshp_pkg::STEP_RATE_SEL:
                        begin
                            step_next = acc_new[0] ? vshp_pkg::STEP_RATE_VAL
                                                   : vshp_pkg::STEP_RATE_NR;
                        end
                        vshp_pkg::STEP_RATE_VAL:
                        begin
                            // Explicit rate: timescale is the value plus one.
                            emit             = 1'b1;
                            item.field_code  = vshp_pkg::CODE_TIMESCALE;
                            item.field_value = {1'b0, acc_new} + 17'd1;
                            pend_next        = 1'b1;
                            pend_val_next    = vshp_pkg::FIXED_DURATION;
                            step_next        = vshp_pkg::STEP_DONE;
                        end
                        vshp_pkg::STEP_RATE_NR:
                        begin
                            nr_idx_next = acc_new[7:0];
                            step_next   = vshp_pkg::STEP_RATE_DR;
                        end
                        vshp_pkg::STEP_RATE_DR:
                        begin
                            // Table rate: both indices in range, or nothing at all.
                            if ((nr_idx_reg >= 8'd1) && (nr_idx_reg <= 8'd5)
                                && (acc_new >= 16'd1) && (acc_new <= 16'd2))
                            begin
                                emit             = 1'b1;
                                item.field_code  = vshp_pkg::CODE_TIMESCALE;
                                item.field_value = vshp_pkg::rate_numerator(nr_idx_reg[2:0]);
                                pend_next        = 1'b1;
                                pend_val_next    = vshp_pkg::rate_denominator(acc_new[1]);
                            end
                            step_next = vshp_pkg::STEP_DONE;
                        end
                        vshp_pkg::STEP_DONE:
                        begin
                            step_next = vshp_pkg::STEP_DONE;
                        end
                        default:
                        begin
                            emit      = 1'b1;
                            step_next = vshp_pkg::step_t'(5'(step_reg) + 5'd1);
                        end
                    endcase
                end
                else
                begin
                    acc_next   = acc_new;
                    fbits_next = fbits_reg + {1'b0, take};
                end

                finished = (bpos_new == 4'd8) || (step_next == vshp_pkg::STEP_DONE);
                if (finished && !head.end_of_buffer)
                begin
                    queue_in.ready = 1'b1;
                    bpos_next      = 4'd0;
                end
                else
                begin
                    bpos_next = bpos_new;
                end
            end
            else if (queue_in.valid)
            begin
                queue_in.ready = 1'b1;
                bpos_next      = 4'd0;
                if (head.end_of_buffer)
                begin
                    emit            = 1'b1;
                    item.is_summary = 1'b1;
                    item.last       = 1'b1;
                    item.status     = sum_status;
                    if ((sum_status == vshp_pkg::STATUS_OK) && (head.byte_count > used))
                    begin
                        item.bytes_left = head.byte_count - used;
                    end
                    step_next   = vshp_pkg::STEP_PROFILE;
                    acc_next    = 16'd0;
                    fbits_next  = 5'd0;
                    cbits_next  = 8'd0;
                    nr_idx_next = 8'd0;
                    pstat_next  = vshp_pkg::STATUS_OK;
                end
            end
        end

        if (emit)
        begin
            ov_next = 1'b1;
            od_next = item;
        end
        else
        begin
            ov_next = ov_reg && !field_out.ready;
            od_next = od_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= vshp_pkg::STEP_PROFILE;
            acc_reg    <= 16'd0;
            fbits_reg  <= 5'd0;
            cbits_reg  <= 8'd0;
            nr_idx_reg <= 8'd0;
            pstat_reg  <= vshp_pkg::STATUS_OK;
            bpos_reg   <= 4'd0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            acc_reg    <= acc_next;
            fbits_reg  <= fbits_next;
            cbits_reg  <= cbits_next;
            nr_idx_reg <= nr_idx_next;
            pstat_reg  <= pstat_next;
            bpos_reg   <= bpos_next;
            pend_reg   <= pend_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_val_reg <= pend_val_next;
        od_reg       <= od_next;
    end
endmodule

// File: sv/video_sequence_header_parser_core.sv
// Sequence header parser for the advanced profile layout. Bytes of one header
// buffer arrive on byte_in, one per transfer, with end_of_buffer marking the
// last byte. The start code bytes are skipped, and the rest is read MSB first
// as a chain of fields; each field but the rate select and table indices
// comes out on field_out once its last bit has arrived, as a field code
// and value. A frame rate in range leaves as a timescale item and then a
// frame duration item. On the final byte a closing transfer carries the
// status and the number of bytes after the header, with last set, and the
// parser is ready for the next buffer. The front end counts and classifies
// bytes and hands them to a four-entry queue, so input transfers keep
// flowing while the field parser works or the output is stalled, as long
// as the queue has room. The field parser takes each byte's bits in
// chunks, one per field that ends in the byte plus one for its remaining
// bits, with a separate step for the frame duration item and the closing
// item; a new byte can be taken every cycle while the queue has room.
module video_sequence_header_parser_core #(
    parameter int MAX_BUFFER_BYTES = 65535,
    parameter int START_CODE_BYTES = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    vshp_stream_if.sink   byte_in,
    vshp_stream_if.source field_out
);
    // Classified bytes between the front end and the queue, and out of the queue.
    vshp_stream_if #(.payload_t(vshp_pkg::queue_item_t)) front_q ();
    vshp_stream_if #(.payload_t(vshp_pkg::queue_item_t)) q_back ();

    vshp_front #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES),
        .START_CODE_BYTES (START_CODE_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .queue_out (front_q)
    );

    vshp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_q),
        .pop   (q_back)
    );

    // The field parser owns the output register, which holds a finished item
    // until the sink takes it.
    vshp_back #(
        .START_CODE_BYTES (START_CODE_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .queue_in  (q_back),
        .field_out (field_out)
    );
endmodule
